>>> hdl/stack_machine_execute_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SME_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SME_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hdl/sme_pkg.sv
// Constants and codes for the stack machine execute unit.
`default_nettype none
package sme_pkg;
    localparam int STACK_DEPTH  = 128;
    localparam int GLOBAL_DEPTH = 256;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int GA_W = $clog2(GLOBAL_DEPTH);
    localparam int IMM_W = 24;

    localparam logic [4:0] OP_HALT = 5'd0, OP_PUSHC = 5'd1, OP_ADD = 5'd2,
        OP_SUB = 5'd3, OP_MUL = 5'd4, OP_DIV = 5'd5, OP_MOD = 5'd6,
        OP_RDINT = 5'd7, OP_WRINT = 5'd8, OP_RDCHR = 5'd9, OP_WRCHR = 5'd10,
        OP_PUSHG = 5'd11, OP_POPG = 5'd12, OP_ASF = 5'd13, OP_RSF = 5'd14,
        OP_PUSHL = 5'd15, OP_POPL = 5'd16;

    localparam logic [2:0] ST_OK = 3'd0, ST_DIVZERO = 3'd1, ST_OVERFLOW = 3'd2,
        ST_UNDERFLOW = 3'd3, ST_INDEX = 3'd4, ST_HALTED = 3'd5;
endpackage
`default_nettype wire

>>> hdl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit.
// The slave channel takes one decoded instruction per beat; the master
// channel returns one result beat per instruction. s_axis_tready is high
// only while the unit is idle and no result is waiting.
// Every instruction passes through S_RD1, which reads the first stack
// operand, S_RD2, which reads the second, S_EXEC, which computes, writes
// back and loads the result register, and S_OUT, after which the result
// beat is presented. The next input beat is accepted only after the result
// beat has been taken. Division and modulo instead run a radix-2 restoring
// divider in S_DIV, which then writes back and loads the result register.
// The stack memory has one read and one write port, which sets the sequence
// of steps. When the receiver stalls, the result holds in the output
// register and no new instruction is taken. Reset clears the stack pointer,
// frame pointer, halt flag and global count; stack and global memories are
// not cleared and are undefined until written. The user must write the global
// count through cfg_wr_en and cfg_wr_data only while the unit is idle; the block does not enforce this.
`default_nettype none
module stack_machine_execute_unit import sme_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[4:0], immediate[28:5], read_value[60:29], zero pad [63:61]
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[2:0], output_valid[3], output_value[35:4], output_is_char[36],
    // halted[37], zero pad [39:38]
    output logic [39:0]      m_axis_tdata
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2,
        S_EXEC = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next, fp_reg, fp_next;
    logic        halt_reg, halt_next;
    logic [8:0]  gcount_reg;
    logic [4:0]  cmd_reg;
    logic signed [IMM_W-1:0] imm_reg;
    logic [31:0] rd_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] glob_mem [GLOBAL_DEPTH];
    logic [31:0] srd_q, grd_q;
    logic [SA_W-1:0] sraddr;
    logic        swe;
    logic [SA_W-1:0] swaddr;
    logic [31:0] swdata;
    logic        gwe;
    logic [39:0] out_reg, out_next;
    logic        ovalid_reg;
    // divider
    logic [5:0]  dcnt_reg, dcnt_next;
    logic [31:0] dq_reg, dq_next, dr_reg, dr_next, dd_reg, dd_next;
    logic [32:0] dtrial;

    logic signed [33:0] gidx, lidx;
    logic [9:0]  glimit;
    logic [SP_W:0] asf_top;
    logic [31:0] res, sext_rd, a_src, a_abs, b_abs, qv, rv;
    logic [2:0]  st;

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    assign glimit = (gcount_reg > 9'(GLOBAL_DEPTH)) ? 10'(GLOBAL_DEPTH)
                                                    : {1'b0, gcount_reg};
    assign gidx = 34'(imm_reg);
    assign lidx = $signed({1'b0, 33'(fp_reg)}) + 34'(imm_reg);
    assign asf_top = (SP_W+1)'(sp_reg) + 1'b1;
    assign sext_rd = {{24{rd_reg[7]}}, rd_reg[7:0]};
    assign a_src = (state_reg == S_EXEC) ? srd_q : a_reg;
    assign a_abs = a_src[31] ? -a_src : a_src;
    assign b_abs = b_reg[31] ? -b_reg : b_reg;
    assign dtrial = {dr_reg, dd_reg[31]} - {1'b0, b_abs};
    assign qv = (a_reg[31] ^ b_reg[31]) ? -dq_reg : dq_reg;
    assign rv = a_reg[31] ? -dr_reg : dr_reg;

    // read address chosen for the S_RD1 and S_RD2 read states
    always_comb begin
        sraddr = SA_W'(sp_reg - 1'b1);
        if (state_reg == S_RD1) begin
            if (cmd_reg == OP_PUSHL) sraddr = SA_W'(lidx);
            else if (cmd_reg == OP_RSF) sraddr = SA_W'(fp_reg - 1'b1);
        end else if (state_reg == S_RD2) begin
            sraddr = SA_W'(sp_reg - 2'd2);
        end
    end

    always_ff @(posedge aclk) begin
        srd_q <= stack_mem[sraddr];
        grd_q <= glob_mem[GA_W'(imm_reg)];
        if (swe) stack_mem[swaddr] <= swdata;
        if (gwe) glob_mem[GA_W'(imm_reg)] <= b_reg;
    end

    always_comb begin
        state_next = state_reg;
        sp_next = sp_reg;
        fp_next = fp_reg;
        halt_next = halt_reg;
        swe = 1'b0;
        swaddr = SA_W'(sp_reg);
        swdata = a_reg;
        gwe = 1'b0;
        out_next = out_reg;
        dcnt_next = dcnt_reg;
        dq_next = dq_reg;
        dr_next = dr_reg;
        dd_next = dd_reg;
        st = ST_OK;
        res = 32'd0;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) state_next = S_RD1;
            end
            S_RD1: state_next = S_RD2;
            S_RD2: state_next = S_EXEC;
            S_EXEC: begin
                if (halt_reg) begin
                    st = ST_HALTED;
                end else begin
                    case (cmd_reg)
                        OP_HALT: halt_next = 1'b1;
                        OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHG: begin
                            if (cmd_reg == OP_PUSHG && (gidx < 0 || gidx >= 34'(glimit)))
                                st = ST_INDEX;
                            else if (sp_reg >= SP_W'(STACK_DEPTH)) st = ST_OVERFLOW;
                            else begin
                                swe = 1'b1;
                                swdata = (cmd_reg == OP_PUSHC) ? 32'(imm_reg) :
                                         (cmd_reg == OP_RDINT) ? rd_reg :
                                         (cmd_reg == OP_RDCHR) ? sext_rd : grd_q;
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                            if (sp_reg < SP_W'(2)) st = ST_UNDERFLOW;
                            else if ((cmd_reg == OP_DIV || cmd_reg == OP_MOD)
                                     && b_reg == 32'd0) st = ST_DIVZERO;
                            else if (cmd_reg == OP_DIV || cmd_reg == OP_MOD) begin
                                dcnt_next = 6'd32;
                                dq_next = 32'd0;
                                dr_next = 32'd0;
                                dd_next = a_abs;
                                state_next = S_DIV;
                            end else begin
                                res = (cmd_reg == OP_ADD) ? a_src + b_reg :
                                      (cmd_reg == OP_SUB) ? a_src - b_reg :
                                      32'(a_src * b_reg);
                                swe = 1'b1;
                                swaddr = SA_W'(sp_reg - 2'd2);
                                swdata = res;
                                sp_next = sp_reg - 1'b1;
                            end
                        end
                        OP_WRINT, OP_WRCHR: begin
                            if (sp_reg == '0) st = ST_UNDERFLOW;
                            else begin
                                sp_next = sp_reg - 1'b1;
                                res = (cmd_reg == OP_WRCHR) ? {{24{b_reg[7]}}, b_reg[7:0]}
                                                            : b_reg;
                            end
                        end
                        OP_POPG: begin
                            if (sp_reg == '0) st = ST_UNDERFLOW;
                            else if (gidx < 0 || gidx >= 34'(glimit)) st = ST_INDEX;
                            else begin
                                sp_next = sp_reg - 1'b1;
                                gwe = 1'b1;
                            end
                        end
                        OP_ASF: begin
                            if (imm_reg < 0) st = ST_INDEX;
                            else if (34'(asf_top) + 34'(imm_reg) > 34'(STACK_DEPTH))
                                st = ST_OVERFLOW;
                            else begin
                                swe = 1'b1;
                                swdata = 32'(fp_reg);
                                fp_next = SP_W'(asf_top);
                                sp_next = SP_W'(34'(asf_top) + 34'(imm_reg));
                            end
                        end
                        OP_RSF: begin
                            if (fp_reg == '0) st = ST_UNDERFLOW;
                            else if (b_reg > 32'(STACK_DEPTH)) st = ST_INDEX;
                            else begin
                                sp_next = fp_reg - 1'b1;
                                fp_next = SP_W'(b_reg);
                            end
                        end
                        OP_PUSHL: begin
                            if (lidx < 0 || lidx >= 34'(STACK_DEPTH)) st = ST_INDEX;
                            else if (sp_reg >= SP_W'(STACK_DEPTH)) st = ST_OVERFLOW;
                            else begin
                                swe = 1'b1;
                                swdata = b_reg;
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        OP_POPL: begin
                            if (sp_reg == '0) st = ST_UNDERFLOW;
                            else if (lidx < 0 || lidx >= 34'(STACK_DEPTH)) st = ST_INDEX;
                            else begin
                                swe = 1'b1;
                                swaddr = SA_W'(lidx);
                                swdata = b_reg;
                                sp_next = sp_reg - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (st != ST_OK) begin
                        halt_next = 1'b1;
                        sp_next = sp_reg;
                        fp_next = fp_reg;
                        swe = 1'b0;
                        gwe = 1'b0;
                    end
                end
                if (state_next != S_DIV) begin
                    out_next = {2'b00, (halt_next || st != ST_OK),
                                (st == ST_OK && cmd_reg == OP_WRCHR),
                                res, 1'b0, st};
                    if (st == ST_OK && !halt_reg &&
                        (cmd_reg == OP_WRINT || cmd_reg == OP_WRCHR))
                        out_next[3] = 1'b1;
                    else out_next[35:4] = 32'd0;
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                if (dcnt_reg == 6'd0) begin
                    res = (cmd_reg == OP_DIV) ? qv : rv;
                    swe = 1'b1;
                    swaddr = SA_W'(sp_reg - 2'd2);
                    swdata = res;
                    sp_next = sp_reg - 1'b1;
                    out_next = {2'b00, halt_reg, 1'b0, 32'd0, 1'b0, ST_OK};
                    state_next = S_OUT;
                end else begin
                    dcnt_next = dcnt_reg - 1'b1;
                    dd_next = {dd_reg[30:0], 1'b0};
                    if (!dtrial[32]) begin
                        dr_next = dtrial[31:0];
                        dq_next = {dq_reg[30:0], 1'b1};
                    end else begin
                        dr_next = {dr_reg[30:0], dd_reg[31]};
                        dq_next = {dq_reg[30:0], 1'b0};
                    end
                end
            end
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            fp_reg <= '0;
            halt_reg <= 1'b0;
            gcount_reg <= 9'd0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            fp_reg <= fp_next;
            halt_reg <= halt_next;
            if (cfg_wr_en) gcount_reg <= cfg_wr_data;
            if (state_reg == S_OUT) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        dcnt_reg <= dcnt_next;
        dq_reg <= dq_next;
        dr_reg <= dr_next;
        dd_reg <= dd_next;
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg <= s_axis_tdata[4:0];
            imm_reg <= s_axis_tdata[28:5];
            rd_reg <= s_axis_tdata[60:29];
        end
        if (state_reg == S_RD2) b_reg <= srd_q;
        if (state_reg == S_EXEC) a_reg <= srd_q;
    end
endmodule
`default_nettype wire

>>> hdl/sme_checker.sv
// Port-level checker for the stack machine execute unit, with its bind.
`default_nettype none
`include "stack_machine_execute_unit_assert.svh"
module sme_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    `SME_ASSERT_IMPL(a_no_accept_while_out, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `SME_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SME_ASSERT_IMPL(a_err_halts, aclk, aresetn, m_axis_tvalid && m_axis_tdata[2:0] != 3'd0, m_axis_tdata[37])
    `SME_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind stack_machine_execute_unit sme_checker u_sme_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the stack machine execute unit.
`default_nettype none
module tb;
    import sme_pkg::*;

    localparam logic [4:0] OP_UNKNOWN_LO = 5'd17;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEMS_PER_PHASE = 300;

    typedef struct packed {
        logic [31:0]        read_value;
        logic signed [23:0] imm;
        logic [4:0]         cmd;
    } instr_t;

    typedef struct {
        logic [2:0]  status;
        bit          out_valid;
        logic [31:0] out_value;
        bit          out_char;
        bit          halted;
    } result_t;

    typedef struct {
        logic [4:0]  cmd;
        logic [23:0] imm;
        logic [31:0] read_value;
        bit          pinned;
        logic [31:0] value;
        bit          out_valid;
        bit          out_char;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    stack_machine_execute_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow machine state.
    logic [31:0] stack_mem [STACK_DEPTH];
    bit          stack_set [STACK_DEPTH];
    logic [31:0] global_mem [GLOBAL_DEPTH];
    bit          global_set [GLOBAL_DEPTH];
    int          stack_ptr;
    int          frame_ptr;
    bit          machine_halted;
    int          global_count;

    result_t     result_q[$];
    bit          pin_en;
    result_t     pin_res;
    int          src_idle_pct;
    int          dst_stall_pct;
    int          mismatches;
    int          cycles;
    row_t        dir_tbl[30];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void execute(input instr_t it, input bit commit,
                                    output result_t res, output bit bad_read);
        int          top;
        int          fb;
        int          immv;
        int          lim;
        longint      idx;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        bit          swr;
        int          swa;
        logic [31:0] swd;
        bit          gwr;
        int          gwa;
        top = stack_ptr;
        fb = frame_ptr;
        immv = it.imm;
        lim = (global_count < GLOBAL_DEPTH) ? global_count : GLOBAL_DEPTH;
        swr = 0; swa = 0; swd = '0; gwr = 0; gwa = 0; r = '0;
        res = '{ST_OK, 0, '0, 0, machine_halted};
        bad_read = 0;
        if (machine_halted) begin
            res.status = ST_HALTED;
            return;
        end
        case (it.cmd)
            OP_HALT: res.halted = 1;
            OP_PUSHC, OP_RDINT, OP_RDCHR: begin
                if (top >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    if (it.cmd == OP_PUSHC) swd = immv;
                    else if (it.cmd == OP_RDINT) swd = it.read_value;
                    else swd = {{24{it.read_value[7]}}, it.read_value[7:0]};
                    swr = 1; swa = top; top++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (top < 2) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    b = stack_mem[top-1];
                    a = stack_mem[top-2];
                    bad_read = !stack_set[top-1] || !stack_set[top-2];
                    case (it.cmd)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        default: begin
                            if (b == 0) res.status = ST_DIVZERO;
                            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                                r = (it.cmd == OP_DIV) ? a : '0;
                            else if (it.cmd == OP_DIV) r = $signed(a) / $signed(b);
                            else r = $signed(a) % $signed(b);
                        end
                    endcase
                    if (res.status == ST_OK) begin
                        top--;
                        swr = 1; swa = top - 1; swd = r;
                    end
                end
            end
            OP_WRINT, OP_WRCHR: begin
                if (top == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    top--;
                    r = stack_mem[top];
                    bad_read = !stack_set[top];
                    res.out_valid = 1;
                    res.out_char = (it.cmd == OP_WRCHR);
                    res.out_value = res.out_char ? {{24{r[7]}}, r[7:0]} : r;
                end
            end
            OP_PUSHG: begin
                if (immv < 0 || immv >= lim) begin
                    res.status = ST_INDEX;
                end else if (top >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    bad_read = !global_set[immv];
                    swr = 1; swa = top; swd = global_mem[immv]; top++;
                end
            end
            OP_POPG: begin
                if (top == 0) begin
                    res.status = ST_UNDERFLOW;
                end else if (immv < 0 || immv >= lim) begin
                    res.status = ST_INDEX;
                end else begin
                    top--;
                    bad_read = !stack_set[top];
                    gwr = 1; gwa = immv;
                end
            end
            OP_ASF: begin
                if (immv < 0) begin
                    res.status = ST_INDEX;
                end else if (top + 1 + immv > STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    swr = 1; swa = top; swd = fb;
                    top++;
                    fb = top;
                    top += immv;
                end
            end
            OP_RSF: begin
                if (fb == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    r = stack_mem[fb-1];
                    bad_read = !stack_set[fb-1];
                    if (r > STACK_DEPTH) begin
                        res.status = ST_INDEX;
                    end else begin
                        top = fb - 1;
                        fb = r;
                    end
                end
            end
            OP_PUSHL: begin
                idx = longint'(fb) + immv;
                if (idx < 0 || idx >= STACK_DEPTH) begin
                    res.status = ST_INDEX;
                end else if (top >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    bad_read = !stack_set[idx];
                    swr = 1; swa = top; swd = stack_mem[idx]; top++;
                end
            end
            OP_POPL: begin
                idx = longint'(fb) + immv;
                if (top == 0) begin
                    res.status = ST_UNDERFLOW;
                end else if (idx < 0 || idx >= STACK_DEPTH) begin
                    res.status = ST_INDEX;
                end else begin
                    top--;
                    bad_read = !stack_set[top];
                    swr = 1; swa = idx; swd = stack_mem[top];
                end
            end
            default: ;
        endcase
        if (res.status != ST_OK) begin
            res.halted = 1;
            res.out_valid = 0;
            res.out_value = '0;
            res.out_char = 0;
        end
        if (!commit) return;
        machine_halted = res.halted;
        if (res.status != ST_OK) return;
        if (gwr) begin
            global_mem[gwa] = stack_mem[top];
            global_set[gwa] = stack_set[top];
        end
        if (swr) begin
            stack_mem[swa] = swd;
            stack_set[swa] = 1;
        end
        stack_ptr = top;
        frame_ptr = fb;
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int lim;
        lim = (global_count < GLOBAL_DEPTH) ? global_count : GLOBAL_DEPTH;
        it.read_value = $urandom;
        it.imm = $urandom;
        if ($urandom_range(99) < 4) it.cmd = $urandom_range(31, OP_UNKNOWN_LO);
        else it.cmd = $urandom_range(OP_POPL, OP_PUSHC);
        case (it.cmd)
            OP_PUSHG, OP_POPG:
                if ($urandom_range(99) < 80) it.imm = $urandom_range(lim > 0 ? lim - 1 : 0);
            OP_PUSHL, OP_POPL:
                if ($urandom_range(99) < 85)
                    it.imm = $urandom_range(STACK_DEPTH - 1) - frame_ptr;
            OP_ASF:
                it.imm = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
            default: ;
        endcase
        return it;
    endfunction

    // Finds an instruction that keeps the machine running, or one that
    // stops it with an error or a halt, and never reads an unwritten entry.
    function automatic instr_t next_instr(input bit want_error);
        instr_t  it;
        result_t res;
        bit      bad;
        for (int n = 0; n < 200; n++) begin
            it = random_instr();
            execute(it, 0, res, bad);
            if (bad || it.cmd == OP_HALT) continue;
            if (want_error == (res.status != ST_OK)) return it;
        end
        it = random_instr();
        it.cmd = want_error ? OP_HALT : OP_UNKNOWN_LO;
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", field, got, want);
        mismatches++;
    endtask

    task automatic send(input instr_t it);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, it};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        pin_en = 0;
    endtask

    task automatic send_op(input logic [4:0] cmd, input logic [23:0] imm);
        instr_t it;
        it.cmd = cmd;
        it.imm = imm;
        it.read_value = $urandom;
        send(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_global_count(input logic [8:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        global_count = value;
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_t res;
        result_t want;
        bit      bad;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            execute(s_axis_tdata[60:0], 1, res, bad);
            result_q.push_back(pin_en ? pin_res : res);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
            end else begin
                want = result_q.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report_mismatch("status", m_axis_tdata[2:0], want.status);
                if (m_axis_tdata[3] != want.out_valid)
                    report_mismatch("output_valid", m_axis_tdata[3], want.out_valid);
                if (m_axis_tdata[35:4] != want.out_value)
                    report_mismatch("output_value", m_axis_tdata[35:4], want.out_value);
                if (m_axis_tdata[36] != want.out_char)
                    report_mismatch("output_is_char", m_axis_tdata[36], want.out_char);
                if (m_axis_tdata[37] != want.halted)
                    report_mismatch("halted", m_axis_tdata[37], want.halted);
            end
        end
    end

    initial begin
        instr_t it;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        pin_en = 0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        mismatches = 0;
        cycles = 0;
        stack_ptr = 0;
        frame_ptr = 0;
        machine_halted = 0;
        global_count = 0;
        foreach (stack_set[i]) stack_set[i] = 0;
        foreach (global_set[i]) global_set[i] = 0;

        dir_tbl = '{
            '{OP_PUSHC, 24'h7FFFFF, 32'h0, 0, 32'h0, 0, 0},
            '{OP_PUSHC, 24'h800000, 32'h0, 0, 32'h0, 0, 0},
            '{OP_WRINT, 24'h000000, 32'h0, 1, 32'hFF80_0000, 1, 0},
            '{OP_WRINT, 24'hFFFFFF, 32'hFFFF_FFFF, 1, 32'h007F_FFFF, 1, 0},
            '{OP_RDINT, 24'h0, 32'h8000_0000, 0, 32'h0, 0, 0},
            '{OP_RDINT, 24'h0, 32'hFFFF_FFFF, 0, 32'h0, 0, 0},
            '{OP_DIV, 24'h0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_RDINT, 24'h0, 32'hFFFF_FFFF, 0, 32'h0, 0, 0},
            '{OP_MOD, 24'h0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_WRINT, 24'h0, 32'h0, 1, 32'h0, 1, 0},
            '{OP_RDCHR, 24'h0, 32'h1234_5680, 0, 32'h0, 0, 0},
            '{OP_WRCHR, 24'h0, 32'h0, 1, 32'hFFFF_FF80, 1, 1},
            '{OP_RDINT, 24'h0, 32'd7, 0, 32'h0, 0, 0},
            '{OP_RDINT, 24'h0, 32'd3, 0, 32'h0, 0, 0},
            '{OP_SUB, 24'h0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_RDCHR, 24'h0, 32'hFFFF_FFFE, 0, 32'h0, 0, 0},
            '{OP_MUL, 24'h0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_PUSHC, 24'd5, 32'h0, 0, 32'h0, 0, 0},
            '{OP_ADD, 24'h0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_POPG, 24'd255, 32'h0, 0, 32'h0, 0, 0},
            '{OP_PUSHG, 24'd255, 32'h0, 0, 32'h0, 0, 0},
            '{OP_WRINT, 24'h0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_ASF, 24'd2, 32'h0, 0, 32'h0, 0, 0},
            '{OP_PUSHC, 24'd9, 32'h0, 0, 32'h0, 0, 0},
            '{OP_POPL, 24'd0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_PUSHL, 24'd0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_POPL, 24'd1, 32'h0, 0, 32'h0, 0, 0},
            '{OP_RSF, 24'd0, 32'h0, 0, 32'h0, 0, 0},
            '{OP_UNKNOWN_LO, 24'h0, 32'h0, 0, 32'h0, 0, 0},
            '{5'd31, 24'h0, 32'h0, 0, 32'h0, 0, 0}
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_global_count(9'd256);
        foreach (dir_tbl[i]) begin
            it.cmd = dir_tbl[i].cmd;
            it.imm = dir_tbl[i].imm;
            it.read_value = dir_tbl[i].read_value;
            pin_en = dir_tbl[i].pinned;
            pin_res = '{ST_OK, dir_tbl[i].out_valid, dir_tbl[i].value,
                        dir_tbl[i].out_char, 0};
            send(it);
        end

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  write_global_count(9'd256); end
                1: begin src_idle_pct = 88; dst_stall_pct = 0;  write_global_count(9'd1); end
                2: begin src_idle_pct = 0;  dst_stall_pct = 88; write_global_count(9'd0); end
                default: begin
                    src_idle_pct = 19;
                    dst_stall_pct = 19;
                    write_global_count($urandom_range(255, 2));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send(next_instr(0));
        end

        // One run ends in a single stopping event, chosen at random.
        drain();
        src_idle_pct = 10;
        dst_stall_pct = 10;
        case ($urandom_range(3))
            0: send_op(OP_HALT, $urandom);
            1: begin
                it.cmd = OP_RDINT;
                it.imm = $urandom;
                it.read_value = $urandom;
                send(it);
                send_op(OP_PUSHC, 24'd0);
                send_op($urandom_range(1) ? OP_DIV : OP_MOD, $urandom);
            end
            2: begin
                while (stack_ptr < STACK_DEPTH) send_op(OP_PUSHC, $urandom);
                send_op(OP_PUSHC, $urandom);
            end
            default: send(next_instr(1));
        endcase
        repeat (4) send(random_instr());

        drain();
        repeat (50) @(negedge aclk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (result_q.size() != 0)
                $display("%0d expected results never arrived", result_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> stack_machine_execute_unit.f
+incdir+hdl
hdl/sme_pkg.sv
hdl/stack_machine_execute_unit.sv
hdl/sme_checker.sv
verif/tb.sv
